// ===== rtl/core/qpr_pkg.sv =====
package qpr_pkg;

  // field and datapath widths
  localparam int FW   = 32;           // field width
  localparam int PW   = 2 * FW;       // quaternion product
  localparam int MW   = PW + 2;       // scaled matrix entry and norm
  localparam int PLW  = FW + 1 + FW;  // low partial product
  localparam int PHW  = MW - FW + FW; // high partial product
  localparam int PPW  = MW + FW;      // full matrix-by-point product
  localparam int NXW  = PPW + 2;      // sum of three products
  localparam int NUMW = NXW + 2;      // rounding numerator 2*|nx| + n
  localparam int DW   = MW;           // divisor 2*n
  localparam int QW   = 32;           // quotient bits produced

  // pre-divide stages, then QW divide stages, then the output register
  localparam int DIV0 = 8;
  localparam int NST  = DIV0 + QW + 1;

  localparam logic [FW-1:0] SAT_POS = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] SAT_NEG = {1'b1, {(FW-1){1'b0}}};

  typedef struct packed {
    logic signed [FW-1:0] point_x;
    logic signed [FW-1:0] point_y;
    logic signed [FW-1:0] point_z;
    logic signed [FW-1:0] quat_real;
    logic signed [FW-1:0] quat_i;
    logic signed [FW-1:0] quat_j;
    logic signed [FW-1:0] quat_k;
  } qpr_in_t;

  typedef struct packed {
    logic signed [FW-1:0] rotated_x;
    logic signed [FW-1:0] rotated_y;
    logic signed [FW-1:0] rotated_z;
    logic                 zero_quaternion;
    logic                 saturated;
  } qpr_out_t;

  // per-word flags that ride alongside the divider lanes
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
    logic [2:0] ovf;
  } qpr_side_t;

endpackage

// ===== rtl/core/qpr_div.sv =====
// One restoring-division lane: one quotient bit per stage, QW stages.
// The caller guarantees rem_init < den whenever the quotient is used.
module qpr_div import qpr_pkg::*; (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] lo  [QW];
  logic [DW-1:0] d   [QW];
  logic [QW-1:0] q   [QW];

  logic [DW-1:0] rem_next [QW];
  logic [QW-1:0] lo_next  [QW];
  logic [DW-1:0] d_next   [QW];
  logic [QW-1:0] q_next   [QW];

  // compare-subtract for each stage
  always_comb begin
    logic [DW-1:0] r_in;
    logic [QW-1:0] l_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        r_in = rem_init;
        l_in = num_lo;
        d_in = den;
        q_in = '0;
      end else begin
        r_in = rem[j-1];
        l_in = lo[j-1];
        d_in = d[j-1];
        q_in = q[j-1];
      end
      t    = {r_in, l_in[QW-1]};
      ge   = t >= {1'b0, d_in};
      diff = t - {1'b0, d_in};
      rem_next[j] = ge ? diff[DW-1:0] : t[DW-1:0];
      lo_next[j]  = {l_in[QW-2:0], 1'b0};
      d_next[j]   = d_in;
      q_next[j]   = {q_in[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      if (en[j]) begin
        rem[j] <= rem_next[j];
        lo[j]  <= lo_next[j];
        d[j]   <= d_next[j];
        q[j]   <= q_next[j];
      end
    end
  end

  assign quo = q[QW-1];

endmodule

// ===== rtl/core/quaternion_point_rotation_core.sv =====
// Rotates a Q16.16 point by a quaternion r, returning the vector part of
// r*(0,p)*conj(r)/|r|^2, rounded to nearest (ties away from zero) and
// saturated to 32 bits; r need not be unit length. A zero quaternion gives
// zero coordinates and sets zero_quaternion. Fully pipelined: one word per
// cycle sustained while dst_ready stays high. The result reaches dst_valid
// through 41 register stages: 8 multiply, add and rounding stages, the
// 32-stage restoring divider (one quotient bit per stage) and the output stage.
// Each stage advances when it is empty or its successor advances, so bubbles
// collapse and a stalled output does not block input until the pipe is full.
module quaternion_point_rotation_core import qpr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  qpr_in_t  src_word,
  output logic     dst_valid,
  input  logic     dst_ready,
  output qpr_out_t dst_word
);

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = ~v[NST-1] | dst_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = ~v[s] | en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= src_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  assign src_ready = en[0];
  assign dst_valid = v[NST-1];

  // stage 0: quaternion products
  logic signed [PW-1:0] aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
  logic signed [FW-1:0] pt0 [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      aa <= src_word.quat_real * src_word.quat_real;
      bb <= src_word.quat_i * src_word.quat_i;
      cc <= src_word.quat_j * src_word.quat_j;
      dd <= src_word.quat_k * src_word.quat_k;
      ab <= src_word.quat_real * src_word.quat_i;
      ac <= src_word.quat_real * src_word.quat_j;
      ad <= src_word.quat_real * src_word.quat_k;
      bc <= src_word.quat_i * src_word.quat_j;
      bd <= src_word.quat_i * src_word.quat_k;
      cd <= src_word.quat_j * src_word.quat_k;
      pt0[0] <= src_word.point_x;
      pt0[1] <= src_word.point_y;
      pt0[2] <= src_word.point_z;
    end
  end

  // stage 1: norm and n-scaled rotation matrix
  logic signed [MW-1:0] m_next [9];
  logic signed [MW-1:0] n_next;
  logic signed [MW-1:0] m1 [9];
  logic        [MW-1:0] n1;
  logic signed [FW-1:0] pt1 [3];

  always_comb begin
    logic signed [MW-1:0] xa, xb, xc, xd;
    xa = MW'(aa);
    xb = MW'(bb);
    xc = MW'(cc);
    xd = MW'(dd);
    n_next    = (xa + xb) + (xc + xd);
    m_next[0] = (xa + xb) - (xc + xd);
    m_next[4] = (xa + xc) - (xb + xd);
    m_next[8] = (xa + xd) - (xb + xc);
    m_next[1] = (MW'(bc) - MW'(ad)) <<< 1;
    m_next[3] = (MW'(bc) + MW'(ad)) <<< 1;
    m_next[2] = (MW'(bd) + MW'(ac)) <<< 1;
    m_next[6] = (MW'(bd) - MW'(ac)) <<< 1;
    m_next[5] = (MW'(cd) - MW'(ab)) <<< 1;
    m_next[7] = (MW'(cd) + MW'(ab)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1  <= m_next;
      n1  <= n_next;
      pt1 <= pt0;
    end
  end

  // stage 2: split partial products of matrix entry by coordinate
  logic signed [PLW-1:0] pl2 [9];
  logic signed [PHW-1:0] ph2 [9];
  logic        [MW-1:0]  n2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pl2[3*i+j] <= $signed({1'b0, m1[3*i+j][FW-1:0]}) * pt1[j];
          ph2[3*i+j] <= $signed(m1[3*i+j][MW-1:FW]) * pt1[j];
        end
      end
      n2 <= n1;
    end
  end

  // stage 3: recombine partial products
  logic signed [PPW-1:0] prod3 [9];
  logic        [MW-1:0]  n3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 9; k++) begin
        prod3[k] <= (PPW'(ph2[k]) <<< FW) + PPW'(pl2[k]);
      end
      n3 <= n2;
    end
  end

  // stage 4: row sums, n times the rotated coordinate
  logic signed [NXW-1:0] nx4 [3];
  logic        [MW-1:0]  n4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        nx4[i] <= NXW'(prod3[3*i]) + NXW'(prod3[3*i+1]) + NXW'(prod3[3*i+2]);
      end
      n4 <= n3;
    end
  end

  // stage 5: sign and magnitude
  logic [NXW-1:0] mag5 [3];
  logic [2:0]     neg5;
  logic [MW-1:0]  n5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        neg5[i] <= nx4[i][NXW-1];
        mag5[i] <= nx4[i][NXW-1] ? NXW'(-nx4[i]) : NXW'(nx4[i]);
      end
      n5 <= n4;
    end
  end

  // stage 6: rounding numerator 2|nx|+n over divisor 2n
  logic [NUMW-1:0] num6 [3];
  logic [DW-1:0]   d6;
  logic [2:0]      neg6;
  logic            zero6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        num6[i] <= NUMW'({mag5[i], 1'b0}) + NUMW'(n5);
      end
      d6    <= {n5[MW-2:0], 1'b0};
      neg6  <= neg5;
      zero6 <= (n5 == '0);
    end
  end

  // stage 7: quotient overflow check and divider seed
  logic [DW-1:0] rem7 [3];
  logic [QW-1:0] lo7  [3];
  logic [DW-1:0] d7;
  qpr_side_t     side7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        rem7[i]      <= num6[i][DW+QW-1:QW];
        lo7[i]       <= num6[i][QW-1:0];
        side7.ovf[i] <= num6[i][NUMW-1:QW] >= (NUMW-QW)'(d6);
      end
      d7         <= d6;
      side7.neg  <= neg6;
      side7.zero <= zero6;
    end
  end

  // divider lanes, flags travel beside them
  logic [QW-1:0] quo [3];
  qpr_side_t     side [QW];

  for (genvar g = 0; g < 3; g++) begin : g_div
    qpr_div u_div (
      .clk      (clk),
      .en       (en[DIV0 +: QW]),
      .rem_init (rem7[g]),
      .num_lo   (lo7[g]),
      .den      (d7),
      .quo      (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      side[0] <= side7;
    end
    for (int j = 1; j < QW; j++) begin
      if (en[DIV0+j]) begin
        side[j] <= side[j-1];
      end
    end
  end

  // output stage: sign, saturation, zero quaternion
  logic [FW-1:0] res [3];
  logic [2:0]    clip;
  qpr_out_t      out_next;

  always_comb begin
    qpr_side_t sd;
    sd = side[QW-1];
    for (int i = 0; i < 3; i++) begin
      if (sd.zero) begin
        clip[i] = 1'b0;
        res[i]  = '0;
      end else if (sd.neg[i]) begin
        clip[i] = sd.ovf[i] | (quo[i] > QW'(SAT_NEG));
        res[i]  = clip[i] ? SAT_NEG : FW'(-quo[i]);
      end else begin
        clip[i] = sd.ovf[i] | quo[i][QW-1];
        res[i]  = clip[i] ? SAT_POS : FW'(quo[i]);
      end
    end
    out_next.rotated_x       = res[0];
    out_next.rotated_y       = res[1];
    out_next.rotated_z       = res[2];
    out_next.zero_quaternion = sd.zero;
    out_next.saturated       = |clip;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      dst_word <= out_next;
    end
  end

endmodule

// ===== verif/quaternion_point_rotation_core_tb.sv =====
`timescale 1ns / 100ps

module quaternion_point_rotation_core_tb;
  import qpr_pkg::*;

  localparam int LATENCY    = 41;
  localparam int N_RANDOM   = 950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 14;

  // value picks for random fields
  typedef enum int {PICK_ANY, PICK_SMALL, PICK_EXTREME, PICK_UNIT} pick_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_ready;
  qpr_in_t  src_word = '0;
  logic     dst_valid;
  logic     dst_ready = 1'b0;
  qpr_out_t dst_word;

  qpr_out_t rotation_q[$];
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned words_in = 0, words_out = 0, n_zero = 0, n_sat = 0;
  int unsigned src_idle_pct = 0, dst_stall_pct = 0;

  quaternion_point_rotation_core dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src_word(src_word),
    .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_word(dst_word)
  );

  always #2 clk = ~clk;

  // round num/den to nearest, ties away from zero, clip to 32 bits
  function automatic logic signed [31:0] round_clip(input logic signed [127:0] num,
                                                    input logic signed [127:0] den,
                                                    inout logic sat);
    logic [127:0] mag, q;
    logic neg;
    neg = num[127];
    mag = neg ? -num : num;
    q = ((mag << 1) + den) / (den << 1);
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return SAT_NEG;
      end
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return SAT_POS;
    end
    return q[31:0];
  endfunction

  // exact rotation r*p*conj(r)/|r|^2 through the scaled rotation matrix
  function automatic qpr_out_t rotate_point(input qpr_in_t w);
    logic signed [127:0] px, py, pz, a, b, c, d, aa, bb, cc, dd;
    logic signed [127:0] ab, ac, ad, bc, bd, cd, n;
    logic signed [127:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    qpr_out_t r;
    logic sat;
    px = w.point_x; py = w.point_y; pz = w.point_z;
    a = w.quat_real; b = w.quat_i; c = w.quat_j; d = w.quat_k;
    aa = a * a; bb = b * b; cc = c * c; dd = d * d;
    ab = a * b; ac = a * c; ad = a * d; bc = b * c; bd = b * d; cd = c * d;
    n = aa + bb + cc + dd;
    r = '0;
    sat = 1'b0;
    if (n == 0) begin
      r.zero_quaternion = 1'b1;
      return r;
    end
    m00 = aa + bb - cc - dd; m11 = aa + cc - bb - dd; m22 = aa + dd - bb - cc;
    m01 = 2 * (bc - ad); m10 = 2 * (bc + ad);
    m02 = 2 * (bd + ac); m20 = 2 * (bd - ac);
    m12 = 2 * (cd - ab); m21 = 2 * (cd + ab);
    r.rotated_x = round_clip(m00 * px + m01 * py + m02 * pz, n, sat);
    r.rotated_y = round_clip(m10 * px + m11 * py + m12 * pz, n, sat);
    r.rotated_z = round_clip(m20 * px + m21 * py + m22 * pz, n, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] pick_value(input pick_t p, input bit is_quat);
    case (p)
      PICK_SMALL:   return $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                : -$urandom_range(0, 65535);
      PICK_EXTREME: case ($urandom_range(0, 3))
                      0: return SAT_POS;
                      1: return SAT_NEG;
                      2: return 32'hFFFF_FFFF;
                      default: return 32'd1;
                    endcase
      PICK_UNIT:    return is_quat ? ($urandom_range(0, 1) ? 32'h4000_0000
                                                            : 32'hC000_0000)
                                   : $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default:      return $urandom;
    endcase
  endfunction

  function automatic qpr_in_t random_word();
    qpr_in_t w;
    w.point_x = pick_value(pick_t'($urandom_range(0, 3)), 0);
    w.point_y = pick_value(pick_t'($urandom_range(0, 3)), 0);
    w.point_z = pick_value(pick_t'($urandom_range(0, 3)), 0);
    w.quat_real = pick_value(pick_t'($urandom_range(0, 3)), 1);
    w.quat_i = pick_value(pick_t'($urandom_range(0, 3)), 1);
    w.quat_j = pick_value(pick_t'($urandom_range(0, 3)), 1);
    w.quat_k = pick_value(pick_t'($urandom_range(0, 3)), 1);
    // occasional zero or single-axis quaternion
    if ($urandom_range(0, 19) == 0) begin
      w.quat_real = '0; w.quat_i = '0; w.quat_j = '0; w.quat_k = '0;
    end else if ($urandom_range(0, 9) == 0) begin
      w.quat_i = '0; w.quat_j = '0;
    end
    return w;
  endfunction

  // directed table: point, quaternion, and a typed-in answer where obvious
  typedef struct {
    qpr_in_t  w;
    bit       has_exp;
    qpr_out_t exp_word;
  } dir_row_t;
  dir_row_t dir_table[N_DIRECTED];

  initial begin
    dir_table[0] = '{'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, '0, '0, '0},
                     1, '{0, 0, 0, 1'b1, 1'b0}};
    dir_table[1] = '{'{SAT_POS, SAT_NEG, 32'hFFFF_FFFF, '0, '0, '0, '0},
                     1, '{0, 0, 0, 1'b1, 1'b0}};
    // identity rotation returns the point
    dir_table[2] = '{'{32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 32'h4000_0000, '0, '0, '0},
                     1, '{32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 1'b0, 1'b0}};
    dir_table[3] = '{'{SAT_POS, SAT_NEG, SAT_POS, 32'h4000_0000, '0, '0, '0},
                     1, '{SAT_POS, SAT_NEG, SAT_POS, 1'b0, 1'b0}};
    // unnormalized identity with the largest magnitudes
    dir_table[4] = '{'{SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, '0, '0, '0},
                     1, '{SAT_NEG, SAT_NEG, SAT_NEG, 1'b0, 1'b0}};
    dir_table[5] = '{'{SAT_POS, SAT_POS, SAT_POS, '0, 32'h4000_0000, '0, '0}, 0, '0};
    dir_table[6] = '{'{SAT_NEG, SAT_POS, 32'h1, '0, '0, SAT_NEG, '0}, 0, '0};
    dir_table[7] = '{'{SAT_NEG, SAT_NEG, SAT_POS, '0, '0, '0, SAT_POS}, 0, '0};
    // 90 degrees about z scaled, and diagonals
    dir_table[8] = '{'{32'h0001_0000, '0, '0, 32'h2D41_3CCD, '0, '0, 32'h2D41_3CCD}, 0, '0};
    dir_table[9] = '{'{SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, '0, '0}, 0, '0};
    dir_table[10] = '{'{SAT_NEG, SAT_NEG, SAT_NEG, 32'h1, 32'h1, 32'h1, 32'h1}, 0, '0};
    dir_table[11] = '{'{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS},
                      0, '0};
    dir_table[12] = '{'{'0, '0, '0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0},
                      1, '{0, 0, 0, 1'b0, 1'b0}};
    dir_table[13] = '{'{32'h1, 32'h1, 32'h1, '0, '0, '0, 32'h1}, 0, '0};
  end

  task automatic send_word(input qpr_in_t w, input bit has_exp, input qpr_out_t exp_word);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_word <= w;
    rotation_q.push_back(has_exp ? exp_word : rotate_point(w));
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    words_in++;
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    while (rotation_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    qpr_out_t want;
    cycles <= cycles + 1;
    if (!rst && dst_valid && dst_ready) begin
      if (rotation_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", dst_word);
      end else begin
        want = rotation_q.pop_front();
        words_out++;
        if (want.zero_quaternion) n_zero++;
        if (want.saturated) n_sat++;
        if (dst_word.rotated_x !== want.rotated_x || dst_word.rotated_y !== want.rotated_y ||
            dst_word.rotated_z !== want.rotated_z ||
            dst_word.zero_quaternion !== want.zero_quaternion ||
            dst_word.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected x=%h y=%h z=%h zq=%b sat=%b, got x=%h y=%h z=%h zq=%b sat=%b",
                     words_out, want.rotated_x, want.rotated_y, want.rotated_z,
                     want.zero_quaternion, want.saturated, dst_word.rotated_x,
                     dst_word.rotated_y, dst_word.rotated_z, dst_word.zero_quaternion,
                     dst_word.saturated);
        end
      end
    end
    dst_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= dst_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    for (int i = 0; i < N_DIRECTED; i++)
      send_word(dir_table[i].w, dir_table[i].has_exp, dir_table[i].exp_word);
    // sender holds off until the pipe drains
    wait_drained();

    // random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 52; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 52; end
        default: begin src_idle_pct = 36; dst_stall_pct = 36; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++)
        send_word(random_word(), 0, '0);
    end
    dst_stall_pct = 0;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d words, checked %0d results (%0d zero quaternion, %0d saturated).",
             words_in, words_out, n_zero, n_sat);
    $display("Covered directed extremes and random words under four idle/stall mixes.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qpr_pkg.sv
rtl/core/qpr_div.sv
rtl/core/quaternion_point_rotation_core.sv
verif/quaternion_point_rotation_core_tb.sv
